// ===== hw/rtl/smc_pkg.sv =====
// Shared types and constants for the small CPU step block.
package smc_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] address;
        logic [7:0] write_byte;
    } t_in_req;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] r2;
        logic [15:0] r3;
        logic        flag_eq;
        logic        flag_lt;
        logic        flag_gt;
        logic        halted;
        logic [7:0]  read_byte;
    } t_out_rsp;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_B0,
        S_B1,
        S_B2,
        S_EX2,
        S_EX3,
        S_LD1,
        S_LD2,
        S_ST,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [4:0] OP_HLT  = 5'd0;
    localparam logic [4:0] OP_NOP  = 5'd1;
    localparam logic [4:0] OP_LDR  = 5'd2;
    localparam logic [4:0] OP_STR  = 5'd3;
    localparam logic [4:0] OP_ADD  = 5'd4;
    localparam logic [4:0] OP_SUB  = 5'd5;
    localparam logic [4:0] OP_MUL  = 5'd6;
    localparam logic [4:0] OP_DIV  = 5'd7;
    localparam logic [4:0] OP_CMP  = 5'd8;
    localparam logic [4:0] OP_MOVR = 5'd9;
    localparam logic [4:0] OP_AND  = 5'd10;
    localparam logic [4:0] OP_OR   = 5'd11;
    localparam logic [4:0] OP_XOR  = 5'd12;
    localparam logic [4:0] OP_NOT  = 5'd13;
    localparam logic [4:0] OP_JEQ  = 5'd14;
    localparam logic [4:0] OP_JNE  = 5'd15;
    localparam logic [4:0] OP_JLT  = 5'd16;
    localparam logic [4:0] OP_JLE  = 5'd17;
    localparam logic [4:0] OP_JGT  = 5'd18;
    localparam logic [4:0] OP_JGE  = 5'd19;
    localparam logic [4:0] OP_JMP  = 5'd20;
    localparam logic [4:0] OP_LOAD = 5'd21;
    localparam logic [4:0] OP_STOR = 5'd22;
    localparam logic [4:0] OP_MOVI = 5'd23;
    localparam logic [4:0] OP_ADDI = 5'd24;
    localparam logic [4:0] OP_SUBI = 5'd25;
    localparam logic [4:0] OP_MULI = 5'd26;
    localparam logic [4:0] OP_DIVI = 5'd27;
    localparam logic [4:0] OP_SHL  = 5'd28;
    localparam logic [4:0] OP_SHR  = 5'd29;
    localparam logic [4:0] OP_RSVD = 5'd30;

endpackage

// ===== hw/rtl/small_cpu_instruction_step.sv =====
// Small byte-addressed CPU that runs one command per request.
//
// Input channel (i_in_valid / o_in_ready, i_in_req) takes one command:
// write a memory byte, execute one instruction, read a memory byte or
// restart. Output channel (o_out_valid / i_out_ready, o_out_rsp) returns
// exactly one response per request with pc, registers, flags, halt and
// the read byte. One request is in flight at a time.
// Instruction and data bytes pass one per cycle through the single memory
// port, and divides wait for the bit-serial divider. After reset all
// MEM_BYTES bytes of memory are cleared one per cycle, with o_in_ready
// low. A stalled response holds in the output register and no new
// request is taken until it has been delivered.
// MEM_BYTES must be a power of two; addresses wrap at the memory size.
module small_cpu_instruction_step
    import smc_pkg::*;
#(
    parameter int MEM_BYTES = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rsp o_out_rsp
);

    localparam int AW = $clog2(MEM_BYTES);

    t_state      r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [15:0] r_gpr [4];
    logic [15:0] n_gpr [4];
    logic [2:0]  r_flags, n_flags;
    logic        r_halt, n_halt;
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_b1, n_b1;
    logic [7:0]  r_b2, n_b2;
    logic [7:0]  r_hi, n_hi;
    logic [7:0]  r_rd, n_rd;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_ovalid, n_ovalid;
    t_out_rsp    r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    logic        div_start;
    logic [15:0] div_num, div_den;
    logic        div_done;
    logic [15:0] div_quot;

    logic [4:0]  w_op;
    logic [1:0]  w_ia, w_ib;
    logic [15:0] w_ra, w_rb, w_k;
    logic [31:0] w_prod;
    logic        w_take;
    logic        w_accept;

    assign w_op     = r_b0[7:3];
    assign w_ia     = r_b0[2:1];
    assign w_ib     = {r_b0[0], r_b1[7]};
    assign w_k      = {r_b1, r_b2};
    assign w_ra     = r_gpr[w_ia];
    assign w_rb     = r_gpr[w_ib];
    assign w_accept = i_in_valid && o_in_ready;

    smc_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    smc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        w_take = 1'b0;
        case (w_op)
            OP_JEQ:  w_take = r_flags[0];
            OP_JNE:  w_take = !r_flags[0];
            OP_JLT:  w_take = r_flags[1];
            OP_JLE:  w_take = r_flags[0] || r_flags[1];
            OP_JGT:  w_take = r_flags[2];
            OP_JGE:  w_take = r_flags[0] || r_flags[2];
            default: w_take = 1'b1;
        endcase
    end

    assign w_prod = w_ra * ((r_state == S_EX3) ? w_k : w_rb);

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_gpr     = r_gpr;
        n_flags   = r_flags;
        n_halt    = r_halt;
        n_b0      = r_b0;
        n_b1      = r_b1;
        n_b2      = r_b2;
        n_hi      = r_hi;
        n_rd      = r_rd;
        n_clr     = r_clr;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_addr  = r_pc[AW-1:0];
        mem_wdata = '0;
        div_start = 1'b0;
        div_num   = w_ra;
        div_den   = w_rb;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_rd  = '0;
                    case (t_cmd'(i_in_req.cmd))
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = AW'(i_in_req.address);
                            mem_wdata = i_in_req.write_byte;
                            n_state   = S_DONE;
                        end
                        CMD_READ: begin
                            mem_addr = AW'(i_in_req.address);
                            n_state  = S_RD;
                        end
                        CMD_EXEC: begin
                            n_state = r_halt ? S_DONE : S_B0;
                        end
                        default: begin
                            n_pc    = '0;
                            n_halt  = 1'b0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_rd    = mem_rdata;
                n_state = S_DONE;
            end
            S_B0: begin
                // opcode byte decides the length
                n_b0     = mem_rdata;
                mem_addr = AW'(r_pc[AW-1:0] + 1'b1);
                if (mem_rdata[7:3] == OP_HLT) begin
                    n_halt  = 1'b1;
                    n_state = S_DONE;
                end else if (mem_rdata[7:3] == OP_NOP) begin
                    n_pc    = r_pc + 16'd1;
                    n_state = S_DONE;
                end else if (mem_rdata[7:3] == OP_NOT) begin
                    n_gpr[mem_rdata[2:1]] = (r_gpr[mem_rdata[2:1]] == '0) ? 16'd1 : 16'd0;
                    n_pc    = r_pc + 16'd1;
                    n_state = S_DONE;
                end else if (mem_rdata[7:3] >= OP_RSVD) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_B1;
                end
            end
            S_B1: begin
                n_b1     = mem_rdata;
                mem_addr = AW'(r_pc[AW-1:0] + 2'd2);
                n_state  = (w_op <= OP_XOR) ? S_EX2 : S_B2;
            end
            S_B2: begin
                n_b2    = mem_rdata;
                n_state = S_EX3;
            end
            S_EX2: begin
                n_pc    = r_pc + 16'd2;
                n_state = S_DONE;
                case (w_op)
                    OP_LDR, OP_MOVR: n_gpr[w_ia] = w_rb;
                    OP_STR:          n_gpr[w_ib] = w_ra;
                    OP_ADD:          n_gpr[w_ia] = w_ra + w_rb;
                    OP_SUB:          n_gpr[w_ia] = w_ra - w_rb;
                    OP_MUL:          n_gpr[w_ia] = w_prod[15:0];
                    OP_DIV: begin
                        div_start = 1'b1;
                        n_pc      = r_pc;
                        n_state   = S_DIV;
                    end
                    OP_CMP: n_flags = {w_ra > w_rb, w_ra < w_rb, w_ra == w_rb};
                    OP_AND: n_gpr[w_ia] = w_ra & w_rb;
                    OP_OR:  n_gpr[w_ia] = w_ra | w_rb;
                    default: n_gpr[w_ia] = w_ra ^ w_rb;
                endcase
            end
            S_EX3: begin
                n_pc    = r_pc + 16'd3;
                n_state = S_DONE;
                div_den = w_k;
                if (w_op <= OP_JMP) begin
                    n_pc = w_take ? w_k : r_pc + 16'd3;
                end else begin
                    case (w_op)
                        OP_LOAD: begin
                            mem_addr = w_k[AW-1:0];
                            n_pc     = r_pc;
                            n_state  = S_LD1;
                        end
                        OP_STOR: begin
                            mem_we    = 1'b1;
                            mem_addr  = w_k[AW-1:0];
                            mem_wdata = w_ra[15:8];
                            n_pc      = r_pc;
                            n_state   = S_ST;
                        end
                        OP_MOVI: n_gpr[w_ia] = w_k;
                        OP_ADDI: n_gpr[w_ia] = w_ra + w_k;
                        OP_SUBI: n_gpr[w_ia] = w_ra - w_k;
                        OP_MULI: n_gpr[w_ia] = w_prod[15:0];
                        OP_DIVI: begin
                            div_start = 1'b1;
                            n_pc      = r_pc;
                            n_state   = S_DIV;
                        end
                        OP_SHL: n_gpr[w_ia] = (w_k >= 16'd16) ? '0 : (w_ra << w_k[3:0]);
                        default: n_gpr[w_ia] = (w_k >= 16'd16) ? '0 : (w_ra >> w_k[3:0]);
                    endcase
                end
            end
            S_LD1: begin
                n_hi     = mem_rdata;
                mem_addr = AW'(w_k[AW-1:0] + 1'b1);
                n_state  = S_LD2;
            end
            S_LD2: begin
                n_gpr[w_ia] = {r_hi, mem_rdata};
                n_pc        = r_pc + 16'd3;
                n_state     = S_DONE;
            end
            S_ST: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(w_k[AW-1:0] + 1'b1);
                mem_wdata = w_ra[7:0];
                n_pc      = r_pc + 16'd3;
                n_state   = S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_gpr[w_ia] = div_quot;
                    n_pc        = r_pc + ((w_op == OP_DIV) ? 16'd2 : 16'd3);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                n_out.program_counter = r_pc;
                n_out.r0              = r_gpr[0];
                n_out.r1              = r_gpr[1];
                n_out.r2              = r_gpr[2];
                n_out.r3              = r_gpr[3];
                n_out.flag_eq         = r_flags[0];
                n_out.flag_lt         = r_flags[1];
                n_out.flag_gt         = r_flags[2];
                n_out.halted          = r_halt;
                n_out.read_byte       = r_rd;
                n_ovalid              = 1'b1;
                n_state               = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_gpr    <= '{default: '0};
            r_flags  <= '0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pc     <= n_pc;
            r_gpr    <= n_gpr;
            r_flags  <= n_flags;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
        end
        r_b0  <= n_b0;
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_hi  <= n_hi;
        r_rd  <= n_rd;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_rsp   = r_out;

endmodule

// ===== hw/rtl/smc_mem.sv =====
// Single-port byte memory with registered read data.
module smc_mem
    import smc_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/smc_div.sv =====
// Restoring 16-bit divider, one quotient bit per cycle.
module smc_div
    import smc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_q, n_q;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [16:0] w_trial;
    logic        w_fit;

    always_comb begin
        w_trial = {r_rem, r_q[15]};
        w_fit   = (w_trial >= {1'b0, r_den});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd15;
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            // a zero divisor always fits, so the quotient comes out all ones
            n_rem = w_fit ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            n_q   = {r_q[14:0], w_fit};
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/smc_checker.sv =====
// Port-level checks for the small CPU step block, bound to the top level.
module smc_checker
    import smc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_rsp o_out_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("request taken while response pending");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken back to back");

    a_single_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("more than one response per request");

endmodule

bind small_cpu_instruction_step smc_checker u_smc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

// ===== tb/sv/smc_step_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts each CPU step response and compares it with the block output.
module smc_step_checker
    import smc_pkg::*;
#(
    parameter int MEM_BYTES = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_out_rsp i_out_rsp,
    output int       o_fail_count,
    output int       o_pending
);

    logic [7:0]  cpu_mem [MEM_BYTES];
    logic [15:0] cpu_reg [4];
    logic [15:0] cpu_pc;
    logic        f_eq, f_lt, f_gt, cpu_halt;
    t_out_rsp    rsp_queue [$];

    function automatic logic [7:0] mem_at(input logic [31:0] a);
        return cpu_mem[a % MEM_BYTES];
    endfunction

    function automatic logic [15:0] quot16(input logic [15:0] n, input logic [15:0] d);
        return (d == 16'd0) ? 16'hFFFF : n / d;
    endfunction

    task automatic exec_instr();
        logic [7:0]  b0;
        logic [4:0]  op;
        logic [23:0] w;
        logic [1:0]  ra, rb;
        logic [15:0] k;
        logic        jump;
        b0 = mem_at(cpu_pc);
        op = b0[7:3];
        if (op == OP_HLT) begin
            cpu_halt = 1'b1;
        end else if (op == OP_NOP) begin
            cpu_pc = cpu_pc + 16'd1;
        end else if (op == OP_NOT) begin
            ra = b0[2:1];
            cpu_reg[ra] = (cpu_reg[ra] == 16'd0) ? 16'd1 : 16'd0;
            cpu_pc = cpu_pc + 16'd1;
        end else if (op <= OP_XOR) begin
            w  = {8'd0, b0, mem_at(cpu_pc + 32'd1)};
            ra = w[10:9];
            rb = w[8:7];
            case (op)
                OP_LDR, OP_MOVR: cpu_reg[ra] = cpu_reg[rb];
                OP_STR: cpu_reg[rb] = cpu_reg[ra];
                OP_ADD: cpu_reg[ra] = cpu_reg[ra] + cpu_reg[rb];
                OP_SUB: cpu_reg[ra] = cpu_reg[ra] - cpu_reg[rb];
                OP_MUL: cpu_reg[ra] = cpu_reg[ra] * cpu_reg[rb];
                OP_DIV: cpu_reg[ra] = quot16(cpu_reg[ra], cpu_reg[rb]);
                OP_CMP: begin
                    f_eq = cpu_reg[ra] == cpu_reg[rb];
                    f_lt = cpu_reg[ra] <  cpu_reg[rb];
                    f_gt = cpu_reg[ra] >  cpu_reg[rb];
                end
                OP_AND: cpu_reg[ra] = cpu_reg[ra] & cpu_reg[rb];
                OP_OR:  cpu_reg[ra] = cpu_reg[ra] | cpu_reg[rb];
                default: cpu_reg[ra] = cpu_reg[ra] ^ cpu_reg[rb];
            endcase
            cpu_pc = cpu_pc + 16'd2;
        end else if (op < OP_RSVD) begin
            w  = {b0, mem_at(cpu_pc + 32'd1), mem_at(cpu_pc + 32'd2)};
            ra = w[18:17];
            k  = w[15:0];
            if (op <= OP_JMP) begin
                case (op)
                    OP_JEQ: jump = f_eq;
                    OP_JNE: jump = !f_eq;
                    OP_JLT: jump = f_lt;
                    OP_JLE: jump = f_eq || f_lt;
                    OP_JGT: jump = f_gt;
                    OP_JGE: jump = f_eq || f_gt;
                    default: jump = 1'b1;
                endcase
                cpu_pc = jump ? k : cpu_pc + 16'd3;
            end else begin
                case (op)
                    OP_LOAD: cpu_reg[ra] = {mem_at(k), mem_at(k + 32'd1)};
                    OP_STOR: begin
                        cpu_mem[k % MEM_BYTES]           = cpu_reg[ra][15:8];
                        cpu_mem[(k + 32'd1) % MEM_BYTES] = cpu_reg[ra][7:0];
                    end
                    OP_MOVI: cpu_reg[ra] = k;
                    OP_ADDI: cpu_reg[ra] = cpu_reg[ra] + k;
                    OP_SUBI: cpu_reg[ra] = cpu_reg[ra] - k;
                    OP_MULI: cpu_reg[ra] = cpu_reg[ra] * k;
                    OP_DIVI: cpu_reg[ra] = quot16(cpu_reg[ra], k);
                    OP_SHL:  cpu_reg[ra] = (k >= 16) ? 16'd0 : cpu_reg[ra] << k;
                    default: cpu_reg[ra] = (k >= 16) ? 16'd0 : cpu_reg[ra] >> k;
                endcase
                cpu_pc = cpu_pc + 16'd3;
            end
        end
    endtask

    task automatic predict_step(input t_in_req req);
        t_out_rsp exp_rsp;
        logic [7:0] rd_val;
        rd_val = 8'd0;
        case (t_cmd'(req.cmd))
            CMD_WRITE:   cpu_mem[req.address % MEM_BYTES] = req.write_byte;
            CMD_EXEC:    if (!cpu_halt) exec_instr();
            CMD_READ:    rd_val = mem_at(req.address);
            default: begin
                cpu_pc   = 16'd0;
                cpu_halt = 1'b0;
            end
        endcase
        exp_rsp = '{cpu_pc, cpu_reg[0], cpu_reg[1], cpu_reg[2], cpu_reg[3],
                    f_eq, f_lt, f_gt, cpu_halt, rd_val};
        rsp_queue.push_back(exp_rsp);
    endtask

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (!i_rst_n) begin
            foreach (cpu_mem[i]) cpu_mem[i] = 8'd0;
            foreach (cpu_reg[i]) cpu_reg[i] = 16'd0;
            cpu_pc = 16'd0;
            {f_eq, f_lt, f_gt, cpu_halt} = 4'd0;
            rsp_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_step(i_in_req);
            if (i_out_valid && i_out_ready) begin
                if (rsp_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected response %h", i_out_rsp);
                end else begin
                    want = rsp_queue.pop_front();
                    if (want !== i_out_rsp) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp pc=%h r=%h %h %h %h eq/lt/gt/h=%b%b%b%b rd=%h | got pc=%h r=%h %h %h %h eq/lt/gt/h=%b%b%b%b rd=%h",
                                want.program_counter, want.r0, want.r1, want.r2, want.r3,
                                want.flag_eq, want.flag_lt, want.flag_gt, want.halted,
                                want.read_byte,
                                i_out_rsp.program_counter, i_out_rsp.r0, i_out_rsp.r1,
                                i_out_rsp.r2, i_out_rsp.r3, i_out_rsp.flag_eq,
                                i_out_rsp.flag_lt, i_out_rsp.flag_gt, i_out_rsp.halted,
                                i_out_rsp.read_byte);
                    end
                end
            end
        end
        o_pending = rsp_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== tb/sv/tb_small_cpu_instruction_step.sv =====
`timescale 1ns / 1ps
// Top-level testbench: stimulus, receiver stalls and verdict for the CPU step block.
module tb_small_cpu_instruction_step
    import smc_pkg::*;
();

    localparam int MEM_BYTES = 256;
    localparam int IDLE_LIMIT = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_rsp out_rsp;
    int       fail_count, pending;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_off = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    small_cpu_instruction_step #(.MEM_BYTES(MEM_BYTES)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_req(in_req), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_rsp(out_rsp)
    );

    smc_step_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_req(in_req), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_rsp(out_rsp), .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until accepted; drop valid only for a gap.
    task automatic send_req(input t_cmd c, input logic [7:0] addr, input logic [7:0] data);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{cmd: c, address: addr, write_byte: data};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic poke(input logic [7:0] addr, input logic [7:0] data);
        send_req(CMD_WRITE, addr, data);
    endtask

    function automatic logic [7:0] rand_b0(input logic [4:0] op);
        return {op, 3'($urandom)};
    endfunction

    // Write a random instruction at addr; returns its length.
    task automatic put_instr(input logic [7:0] addr, input logic [4:0] op, output int len);
        logic [7:0] b1, b2;
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        if (op >= OP_SHL && $urandom_range(0, 3) != 0) begin
            b1 = 8'd0;
            b2 = 8'($urandom_range(0, 17));
        end else if (op >= OP_JEQ && op <= OP_JMP) begin
            b1 = 8'd0;
            b2 = 8'($urandom_range(0, 40));
        end else if ((op == OP_DIVI || op == OP_DIV) && $urandom_range(0, 3) == 0) begin
            b1 = 8'd0;
            b2 = 8'd0;
        end
        poke(addr, rand_b0(op));
        len = (op == OP_HLT || op == OP_NOP || op == OP_NOT) ? 1 : (op <= OP_XOR ? 2 : 3);
        if (len > 1) poke(addr + 8'd1, b1);
        if (len > 2) poke(addr + 8'd2, b2);
    endtask

    initial begin
        int len, n_items;
        logic [4:0] op;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: divide by zero, jump to 0xFE, reserved opcode, read, restart and halt
        poke(8'd0, {OP_MOVI, 2'd1, 1'b0}); poke(8'd1, 8'hFF); poke(8'd2, 8'hFF);
        send_req(CMD_EXEC, 8'd0, 8'd0);
        poke(8'd3, {OP_DIVI, 2'd0, 1'b0}); poke(8'd4, 8'd0); poke(8'd5, 8'd0);
        send_req(CMD_EXEC, 8'd0, 8'd0);
        poke(8'd6, {OP_CMP, 3'b010}); poke(8'd7, 8'h80);
        send_req(CMD_EXEC, 8'd0, 8'd0);
        poke(8'd8, {OP_JMP, 3'd0}); poke(8'd9, 8'h00); poke(8'd10, 8'hFE);
        send_req(CMD_EXEC, 8'd0, 8'd0);
        poke(8'hFE, {OP_RSVD, 3'd7}); poke(8'hFF, {OP_NOP, 3'd0});
        send_req(CMD_EXEC, 8'd0, 8'd0);
        send_req(CMD_READ, 8'hFF, 8'hAA);
        send_req(CMD_RESTART, 8'h55, 8'hFF);
        poke(8'd0, 8'd0);
        send_req(CMD_EXEC, 8'd0, 8'd0);
        send_req(CMD_EXEC, 8'd0, 8'd0);

        // random: mostly restart-and-run programs built from random instructions
        n_items = 0;
        while (n_items < 650) begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 7) begin
                int pos;
                send_req(CMD_RESTART, 8'($urandom), 8'($urandom));
                pos = 0;
                repeat ($urandom_range(2, 6)) begin
                    op = 5'($urandom_range(1, 31));
                    if (op == OP_HLT) op = OP_NOP;
                    put_instr(8'(pos), op, len);
                    pos += len;
                    n_items += len;
                end
                if ($urandom_range(0, 3) == 0) poke(8'(pos), rand_b0(OP_HLT));
                repeat ($urandom_range(2, 8)) begin
                    send_req(CMD_EXEC, 8'($urandom), 8'($urandom));
                    n_items++;
                end
            end else begin
                send_req(t_cmd'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                n_items++;
            end
            if (n_items > 300 && n_items < 330 && !hold_off) begin
                hold_off = 1'b1;
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial begin
        int g;
        bit done_hold;
        done_hold = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off && !done_hold) begin
                done_hold = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            g = gap_len();
            if (g == 0 || $urandom_range(0, 1)) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
